FILE: rtl/core/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared constants, widths and status codes for the scheduler core.
// ----------------------------------------------------------------------------
`default_nettype none
package lts_pkg;
    localparam int SLOTS_DEF       = 16;
    localparam int TICKET_BITS_DEF = 10;
    localparam int ID_W            = 16;
    localparam int TCNT_W          = 10;
    localparam int RND_W           = 32;
    localparam int TOT_OUT_W       = 14;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_DRAW = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/lts_if.sv
// ----------------------------------------------------------------------------
// Lottery scheduler channel interfaces
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface lts_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [lts_pkg::ID_W-1:0]   proc_id;
    logic [lts_pkg::TCNT_W-1:0] tickets;
    logic [lts_pkg::RND_W-1:0]  random_value;
    modport source (output valid, req_type, proc_id, tickets, random_value,
                    input ready);
    modport sink   (input valid, req_type, proc_id, tickets, random_value,
                    output ready);
endinterface

interface lts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [lts_pkg::ID_W-1:0]      chosen_id;
    logic [lts_pkg::TOT_OUT_W-1:0] ticket_total;
    modport source (output valid, status, chosen_id, ticket_total, input ready);
    modport sink   (input valid, status, chosen_id, ticket_total, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lottery_ticket_scheduler_core.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler core
// Holds ready threads in a ring of cells and draws a ticket-weighted winner.
// ----------------------------------------------------------------------------
// Channel | Dir | Word
// i_req   | in  | req_type, proc_id, tickets, random_value
// o_rsp   | out | status, chosen_id, ticket_total
//
// The table is a ring of SLOTS cells; the first n cells hold the entries and
// cell 0 is the head. Every request first sums the tickets by rotating the
// ring once through S_SUM; an add or a draw that ends early (empty table, zero
// total) then goes straight to S_DONE. A full draw starts the divider in S_MOD,
// waits for the serial modulo in S_WAIT and walks the ring once more in S_WALK
// before S_DONE. Reset (synchronous, active low) empties the table, returns
// the control to S_IDLE and clears the result valid. A result waits in its
// output register; the next request is taken meanwhile and only its final
// state, S_DONE, stalls until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module lottery_ticket_scheduler_core #(
    parameter int SLOTS       = lts_pkg::SLOTS_DEF,
    parameter int TICKET_BITS = lts_pkg::TICKET_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lts_req_if.sink   i_req,
    lts_rsp_if.source o_rsp
);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int SUMW = TICKET_BITS + $clog2(SLOTS + 1);
    localparam int OW   = lts_pkg::TOT_OUT_W;

    localparam logic [2:0] S_IDLE = 3'd0, S_SUM = 3'd1, S_MOD = 3'd2,
                           S_WAIT = 3'd3, S_WALK = 3'd4, S_DONE = 3'd5;

    logic [2:0]                r_st;
    logic [CNTW-1:0]           r_count, r_step;
    logic [SUMW-1:0]           r_sum, r_run, r_draw;
    logic                      r_req;
    logic [lts_pkg::ID_W-1:0]  r_tid;
    logic [TICKET_BITS-1:0]    r_tk;
    logic [lts_pkg::RND_W-1:0] r_rnd;
    logic                      r_found, r_ov;
    logic [1:0]                r_wstatus;
    logic [lts_pkg::ID_W-1:0]  r_wchosen;
    logic [1:0]                r_status;
    logic [lts_pkg::ID_W-1:0]  r_chosen;
    logic [OW-1:0]             r_total;

    logic [lts_pkg::ID_W-1:0] w_id [SLOTS];
    logic [TICKET_BITS-1:0]   w_tk [SLOTS];
    logic [lts_pkg::ID_W-1:0] w_nid [SLOTS];
    logic [TICKET_BITS-1:0]   w_ntk [SLOTS];
    logic                     w_rot, w_drop, w_move, w_mod_start, w_mod_done;
    logic                     w_fire, w_take, w_append;
    logic [SUMW-1:0]          w_rem, w_run_nx;

    // Ring over the active prefix [0, count): each cell takes its successor and
    // the last active cell takes the head. On a drop the head word is lost and
    // the prefix shrinks by one. An append loads the cell just past the prefix.
    genvar g;
    for (g = 0; g < SLOTS; g++) begin : g_cell
        logic w_ld;
        assign w_ld = w_append && (CNTW'(g) == r_count);
        if (g == SLOTS - 1) begin : g_last
            assign w_nid[g] = w_ld ? r_tid : w_id[0];
            assign w_ntk[g] = w_ld ? r_tk  : w_tk[0];
        end else begin : g_mid
            assign w_nid[g] = w_ld ? r_tid :
                              ((CNTW'(g + 1) == r_count) && !w_drop) ? w_id[0] : w_id[g+1];
            assign w_ntk[g] = w_ld ? r_tk :
                              ((CNTW'(g + 1) == r_count) && !w_drop) ? w_tk[0] : w_tk[g+1];
        end
        lts_cell #(.TB(TICKET_BITS)) u_cell (
            .i_clk(i_clk), .i_shift(w_move && (CNTW'(g) < r_count)),
            .i_load(w_ld),
            .i_id(w_nid[g]), .i_tk(w_ntk[g]), .o_id(w_id[g]), .o_tk(w_tk[g]));
    end

    assign w_run_nx = r_run + SUMW'(w_tk[0]);

    lts_mod #(.TW(SUMW)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start),
        .i_num(r_rnd), .i_den(r_sum), .o_done(w_mod_done), .o_rem(w_rem));

    // The walk visits the entries in order; the first one whose running sum
    // passes the draw is dropped, and the rotation continues until the ring is
    // back in its original order.
    assign w_mod_start = (r_st == S_MOD);
    assign w_drop  = (r_st == S_WALK) && (r_step != '0) && !r_found && (w_run_nx > r_draw);
    assign w_rot   = ((r_st == S_SUM) || (r_st == S_WALK)) && (r_step != '0) && !w_drop;
    assign w_move  = w_rot || w_drop;
    assign w_take  = r_ov && o_rsp.ready;
    assign w_fire  = (r_st == S_DONE) && (!r_ov || o_rsp.ready);
    assign w_append = w_fire && (r_req == lts_pkg::REQ_ADD) && (r_count != CNTW'(SLOTS));
    assign i_req.ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_count <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_fire) r_ov <= 1'b1;
            else if (w_take) r_ov <= 1'b0;
            if (w_fire) begin
                r_status <= r_wstatus;
                r_chosen <= r_wchosen;
                r_total  <= OW'(r_sum);
            end
            case (r_st)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.req_type; r_tid <= i_req.proc_id;
                        r_tk  <= TICKET_BITS'(i_req.tickets);
                        r_rnd <= i_req.random_value;
                        r_sum <= '0; r_step <= r_count; r_st <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_step != '0) begin
                        r_sum  <= r_sum + SUMW'(w_tk[0]);
                        r_step <= r_step - CNTW'(1);
                    end else if (r_req == lts_pkg::REQ_ADD) begin
                        if (r_count == CNTW'(SLOTS)) begin
                            r_wstatus <= lts_pkg::ST_FULL; r_wchosen <= '0;
                        end else begin
                            r_wstatus <= lts_pkg::ST_OK; r_wchosen <= r_tid;
                        end
                        r_st <= S_DONE;
                    end else if (r_count == '0) begin
                        r_wstatus <= lts_pkg::ST_EMPTY; r_wchosen <= '0; r_st <= S_DONE;
                    end else if (r_sum == '0) begin
                        r_wstatus <= lts_pkg::ST_ZERO; r_wchosen <= '0; r_st <= S_DONE;
                    end else begin
                        r_st <= S_MOD;
                    end
                end
                S_MOD: r_st <= S_WAIT;
                S_WAIT: begin
                    if (w_mod_done) begin
                        r_draw <= w_rem; r_run <= '0; r_found <= 1'b0;
                        r_step <= r_count; r_st <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_step == '0) begin
                        r_wstatus <= lts_pkg::ST_OK; r_st <= S_DONE;
                    end else begin
                        if (w_drop) begin
                            r_wchosen <= w_id[0]; r_found <= 1'b1;
                            r_count <= r_count - CNTW'(1);
                        end else begin
                            r_run <= w_run_nx;
                        end
                        r_step <= r_step - CNTW'(1);
                    end
                end
                S_DONE: begin
                    if (w_fire) begin
                        r_st <= S_IDLE;
                        if (w_append) r_count <= r_count + CNTW'(1);
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_status;
    assign o_rsp.chosen_id    = r_chosen;
    assign o_rsp.ticket_total = r_total;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(SLOTS)) else $error("count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> r_ov) else $error("result lost");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> ($stable(o_rsp.chosen_id) && $stable(o_rsp.status)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

FILE: rtl/core/lts_cell.sv
// ----------------------------------------------------------------------------
// Lottery scheduler table cell
// One slot of the table; takes its neighbor's word on a shift or a new entry on a load.
// ----------------------------------------------------------------------------
`default_nettype none
module lts_cell #(
    parameter int TB = lts_pkg::TICKET_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_shift,
    input  wire logic                     i_load,
    input  wire logic [lts_pkg::ID_W-1:0] i_id,
    input  wire logic [TB-1:0]            i_tk,
    output logic      [lts_pkg::ID_W-1:0] o_id,
    output logic      [TB-1:0]            o_tk
);
    logic [lts_pkg::ID_W-1:0] r_id;
    logic [TB-1:0]            r_tk;
    always_ff @(posedge i_clk) begin
        if (i_shift || i_load) begin
            r_id <= i_id;
            r_tk <= i_tk;
        end
    end
    assign o_id = r_id;
    assign o_tk = r_tk;
endmodule
`default_nettype wire

FILE: rtl/core/lts_mod.sv
// ----------------------------------------------------------------------------
// Serial modulo unit
// Restoring remainder of a 32-bit value by the ticket total, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lts_mod #(
    parameter int TW = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lts_pkg::RND_W-1:0]   i_num,
    input  wire logic [TW-1:0]               i_den,
    output logic                             o_done,
    output logic      [TW-1:0]               o_rem
);
    localparam int CW = $clog2(lts_pkg::RND_W + 1);
    logic [lts_pkg::RND_W-1:0] r_num;
    logic [TW-1:0]             r_rem;
    logic [TW-1:0]             r_den;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic [TW:0]               n_try;
    logic [TW:0]               n_diff;

    // The remainder stays below the divisor, so the top bit of the difference
    // is the borrow of the trial subtraction.
    assign n_try  = {r_rem, r_num[lts_pkg::RND_W-1]};
    assign n_diff = n_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(lts_pkg::RND_W);
            end else if (r_busy) begin
                r_num <= {r_num[lts_pkg::RND_W-2:0], 1'b0};
                if (!n_diff[TW]) r_rem <= n_diff[TW-1:0];
                else r_rem <= n_try[TW-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_rem = r_rem;
endmodule
`default_nettype wire

FILE: tb/lottery_ticket_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// Lottery ticket scheduler core testbench
// Drives add and draw requests through the valid/ready request channel,
// predicts each result word from a behavioral copy of the thread table,
// and compares the result words field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module lottery_ticket_scheduler_core_tb;
    localparam int SLOTS       = lts_pkg::SLOTS_DEF;
    localparam int TICKET_BITS = lts_pkg::TICKET_BITS_DEF;
    localparam int ID_W        = lts_pkg::ID_W;
    localparam int TCNT_W      = lts_pkg::TCNT_W;
    localparam int RND_W       = lts_pkg::RND_W;
    localparam int TOT_OUT_W   = lts_pkg::TOT_OUT_W;
    localparam int N_RANDOM    = 530;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_W-1:0]      chosen_id;
        logic [TOT_OUT_W-1:0] ticket_total;
    } t_result;

    // One row of the directed table; check_fixed marks rows whose result is
    // typed in by hand rather than taken from the predictor.
    typedef struct {
        logic              req_type;
        logic [ID_W-1:0]   proc_id;
        logic [TCNT_W-1:0] tickets;
        logic [RND_W-1:0]  random_value;
        bit                check_fixed;
        t_result           fixed;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    lts_req_if req_ch();
    lts_rsp_if rsp_ch();

    lottery_ticket_scheduler_core #(.SLOTS(SLOTS), .TICKET_BITS(TICKET_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Behavioral copy of the thread table.
    logic [ID_W-1:0]        table_ids[SLOTS];
    logic [TICKET_BITS-1:0] table_tickets[SLOTS];
    int                     table_len;

    t_result pending_results[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    longint  cycle_count;

    // Works out the result word of one request and updates the table.
    function automatic t_result schedule_request(logic rtype, logic [ID_W-1:0] tid,
                                                 logic [TCNT_W-1:0] tcnt,
                                                 logic [RND_W-1:0] rnd);
        t_result r;
        longint unsigned total;
        longint unsigned draw;
        longint unsigned running;
        int win;
        total = 0;
        for (int i = 0; i < table_len; i++) total += table_tickets[i];
        r.status = lts_pkg::ST_OK;
        r.chosen_id = '0;
        r.ticket_total = total[TOT_OUT_W-1:0];
        if (rtype == lts_pkg::REQ_ADD) begin
            if (table_len >= SLOTS) begin
                r.status = lts_pkg::ST_FULL;
            end else begin
                table_ids[table_len] = tid;
                table_tickets[table_len] = TICKET_BITS'(tcnt);
                table_len++;
                r.chosen_id = tid;
            end
        end else if (table_len == 0) begin
            r.status = lts_pkg::ST_EMPTY;
        end else if (total == 0) begin
            r.status = lts_pkg::ST_ZERO;
        end else begin
            draw = longint'(rnd) % total;
            running = 0;
            win = 0;
            for (int i = 0; i < table_len; i++) begin
                running += table_tickets[i];
                if (running > draw) begin
                    win = i;
                    break;
                end
            end
            r.chosen_id = table_ids[win];
            for (int i = win; i + 1 < table_len; i++) begin
                table_ids[i] = table_ids[i + 1];
                table_tickets[i] = table_tickets[i + 1];
            end
            table_len--;
        end
        return r;
    endfunction

    // Presents one request word and holds it until the block takes it. Called
    // at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(logic rtype, logic [ID_W-1:0] tid,
                                logic [TCNT_W-1:0] tcnt, logic [RND_W-1:0] rnd,
                                bit check_fixed, t_result fixed);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= rtype;
        req_ch.proc_id      <= tid;
        req_ch.tickets      <= tcnt;
        req_ch.random_value <= rnd;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = schedule_request(rtype, tid, tcnt, rnd);
        if (check_fixed && predicted != fixed) begin
            $error("directed row disagrees with predictor: %h vs %h", fixed, predicted);
            fail_count++;
        end
        pending_results.push_back(check_fixed ? fixed : predicted);
        @(negedge i_clk);
    endtask

    // Result side: random stalls, and each taken word is compared with the oldest
    // expectation.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.chosen_id !== want.chosen_id) begin
                    $error("chosen_id: expected %0d, got %0d",
                           want.chosen_id, rsp_ch.chosen_id);
                    fail_count++;
                end
                if (rsp_ch.ticket_total !== want.ticket_total) begin
                    $error("ticket_total: expected %0d, got %0d",
                           want.ticket_total, rsp_ch.ticket_total);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_directed_row row(logic rtype, logic [ID_W-1:0] tid,
                                          logic [TCNT_W-1:0] tcnt,
                                          logic [RND_W-1:0] rnd, bit fx = 0,
                                          logic [1:0] st = lts_pkg::ST_OK,
                                          logic [ID_W-1:0] cid = '0,
                                          logic [TOT_OUT_W-1:0] tot = '0);
        t_directed_row d;
        d.req_type = rtype;
        d.proc_id = tid;
        d.tickets = tcnt;
        d.random_value = rnd;
        d.check_fixed = fx;
        d.fixed = '{st, cid, tot};
        return d;
    endfunction

    initial begin
        t_directed_row directed[$];
        int phase_len;
        logic rtype;
        table_len = 0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 28;
        recv_idle_pct = 73;
        req_ch.valid = 1'b0;
        req_ch.req_type = lts_pkg::REQ_ADD;
        req_ch.proc_id = '0;
        req_ch.tickets = '0;
        req_ch.random_value = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty draw after reset, zero-ticket entries, extremes, table full.
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF, 1,
                               lts_pkg::ST_EMPTY, 0, 0));
        directed.push_back(row(lts_pkg::REQ_ADD, 16'h0000, 10'd0, 32'h0, 1,
                               lts_pkg::ST_OK, 16'h0000, 0));
        directed.push_back(row(lts_pkg::REQ_ADD, 16'hFFFF, 10'd0, 32'hFFFF_FFFF, 1,
                               lts_pkg::ST_OK, 16'hFFFF, 0));
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'h0, 10'h0, 32'h1234_5678, 1,
                               lts_pkg::ST_ZERO, 0, 0));
        directed.push_back(row(lts_pkg::REQ_ADD, 16'hA5A5, 10'h3FF, 32'h0, 1,
                               lts_pkg::ST_OK, 16'hA5A5, 0));
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'h0, 10'h0, 32'h0, 1,
                               lts_pkg::ST_OK, 16'hA5A5, 1023));
        for (int i = 0; i < 15; i++)
            directed.push_back(row(lts_pkg::REQ_ADD, 16'(i * 4369), 10'h3FF, 32'h0));
        directed.push_back(row(lts_pkg::REQ_ADD, 16'h5A5A, 10'h155, 32'h0));
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'h0, 10'h0, 32'hFFFF_FFFF));
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'h0, 10'h0, 32'h0));
        directed.push_back(row(lts_pkg::REQ_DRAW, 16'h0, 10'h0, 32'h8000_0000));

        foreach (directed[k])
            send_request(directed[k].req_type, directed[k].proc_id,
                         directed[k].tickets, directed[k].random_value,
                         directed[k].check_fixed, directed[k].fixed);

        // Random part in three idling phases; the add share drifts so the table
        // swings between empty and full.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 73 : 0;
            recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 28 : 0;
            phase_len = N_RANDOM / 3;
            for (int n = 0; n < phase_len; n++) begin
                if ((n / 40) % 2 == 0)
                    rtype = ($urandom_range(99) < 65) ? lts_pkg::REQ_ADD : lts_pkg::REQ_DRAW;
                else
                    rtype = ($urandom_range(99) < 35) ? lts_pkg::REQ_ADD : lts_pkg::REQ_DRAW;
                send_request(rtype, 16'($urandom),
                             ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom),
                             $urandom, 0, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
